FILE: rtl/anbs_pkg.sv
// Shared types and constants for the Annex B unit splitter.
package anbs_pkg;

	localparam int LENGTH_BITS_DEF = 24;
	localparam int UNIT_LEN_W = 24;

	// Start code lengths as reported with each unit
	localparam logic [2:0] PFX_NONE  = 3'd0;
	localparam logic [2:0] PFX_SHORT = 3'd3;
	localparam logic [2:0] PFX_LONG  = 3'd4;

	// Range of unit types counted as known
	localparam logic [4:0] TYPE_FIRST = 5'd1;
	localparam logic [4:0] TYPE_LAST  = 5'd12;

	// Number of bytes held back before a position may be examined
	localparam logic [2:0] WIN_FULL = 3'd4;

	// Output queue: two pushes a cycle at most, one pop
	localparam int OQ_DEPTH    = 8;
	localparam int OQ_PTR_W    = 3;
	localparam int OQ_CNT_W    = 4;
	localparam int OQ_HEADROOM = 4;

	typedef struct packed {
		logic [UNIT_LEN_W-1:0] unit_length;
		logic [2:0]            prefix_length;
		logic                  forbidden_bit;
		logic [1:0]            reference_level;
		logic [4:0]            unit_type;
		logic                  type_known;
		logic                  final_unit;
	} result_t;

	// Writes into the output queue in one cycle; second implies first
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

endpackage

FILE: rtl/anbs_if.sv
// Stream and result channel interfaces of the Annex B unit splitter.
interface anbs_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       stream_end;

	modport source(output valid, stream_byte, stream_end, input ready);
	modport sink(input valid, stream_byte, stream_end, output ready);
endinterface

interface anbs_unit_if;
	import anbs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [UNIT_LEN_W-1:0] unit_length;
	logic [2:0]            prefix_length;
	logic                  forbidden_bit;
	logic [1:0]            reference_level;
	logic [4:0]            unit_type;
	logic                  type_known;
	logic                  final_unit;

	modport source(output valid, unit_length, prefix_length, forbidden_bit, reference_level,
		unit_type, type_known, final_unit, input ready);
	modport sink(input valid, unit_length, prefix_length, forbidden_bit, reference_level,
		unit_type, type_known, final_unit, output ready);
endinterface

FILE: rtl/anbs_scan.sv
// Start code scanner: byte window, unit state and result building.
module anbs_scan #(
	parameter int LENGTH_BITS = anbs_pkg::LENGTH_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic [7:0]        item_byte,
	input  logic              item_end,
	output anbs_pkg::push_t   push,
	output anbs_pkg::result_t res0,
	output anbs_pkg::result_t res1
);
	import anbs_pkg::*;

	logic [31:0]            win_q, win_n;
	logic [2:0]             fill_q, fill_n;
	logic [1:0]             skip_q, skip_n;
	logic [LENGTH_BITS-1:0] count_q, count_n;
	logic [2:0]             pfx_q, pfx_n;
	logic [7:0]             hdr_q, hdr_n;
	logic                   pend_q, pend_n;

	logic      a_valid, b_valid;
	result_t   res_a, res_b;
	logic [2:0] code, skip_e, rest;
	logic [2:0] hdr_pos;

	function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] c,
			input logic [2:0] n);
		logic [LENGTH_BITS:0] sum;
		sum = {1'b0, c} + (LENGTH_BITS+1)'(n);
		if (sum[LENGTH_BITS]) begin
			return {LENGTH_BITS{1'b1}};
		end
		return sum[LENGTH_BITS-1:0];
	endfunction

	function automatic result_t build(input logic [LENGTH_BITS-1:0] c, input logic [2:0] p,
			input logic [7:0] hb, input logic pnd, input logic fin);
		result_t    r;
		logic       has_hdr;
		logic [7:0] h;
		logic [31:0] wide;
		has_hdr = (p != PFX_NONE) && !pnd;
		h = has_hdr ? hb : 8'h00;
		wide = 32'(c);
		r.unit_length = wide[UNIT_LEN_W-1:0];
		r.prefix_length = p;
		r.forbidden_bit = h[7];
		r.reference_level = h[6:5];
		r.unit_type = h[4:0];
		r.type_known = has_hdr && (h[4:0] >= TYPE_FIRST) && (h[4:0] <= TYPE_LAST);
		r.final_unit = fin;
		return r;
	endfunction

	always_comb begin
		win_n = win_q;
		fill_n = fill_q;
		skip_n = skip_q;
		count_n = count_q;
		pfx_n = pfx_q;
		hdr_n = hdr_q;
		pend_n = pend_q;
		a_valid = 1'b0;
		b_valid = 1'b0;
		res_a = '0;
		res_b = '0;
		code = PFX_NONE;
		skip_e = '0;
		rest = '0;
		hdr_pos = '0;
		if (item_valid) begin
			if (fill_q == WIN_FULL) begin
				// The oldest byte now has four bytes after it and can be examined.
				if (skip_q != 2'd0) begin
					skip_n = skip_q - 2'd1;
				end else begin
					if (win_q[31:24] == 8'h00 && win_q[23:16] == 8'h00 && win_q[15:8] == 8'h01) begin
						code = PFX_SHORT;
					end else if (win_q[31:24] == 8'h00 && win_q[23:16] == 8'h00
							&& win_q[15:8] == 8'h00 && win_q[7:0] == 8'h01) begin
						code = PFX_LONG;
					end
					if (code != PFX_NONE) begin
						if (count_q != '0) begin
							a_valid = 1'b1;
							res_a = build(count_q, pfx_q, hdr_q, pend_q, 1'b0);
						end
						count_n = LENGTH_BITS'(code);
						pfx_n = code;
						skip_n = 2'(code - 3'd1);
						hdr_n = 8'h00;
						pend_n = 1'b1;
					end else begin
						count_n = sat_add(count_q, 3'd1);
						if (pend_q) begin
							hdr_n = win_q[31:24];
							pend_n = 1'b0;
						end
					end
				end
			end else begin
				fill_n = fill_q + 3'd1;
			end
			win_n = {win_q[23:0], item_byte};

			if (item_end) begin
				// Flush: bytes still in the window that are not start code belong to the unit.
				skip_e = ({1'b0, skip_n} < fill_n) ? {1'b0, skip_n} : fill_n;
				rest = fill_n - skip_e;
				if (rest != 3'd0) begin
					count_n = sat_add(count_n, rest);
					if (pend_n) begin
						hdr_pos = fill_n - 3'd1 - skip_e;
						hdr_n = win_n[8*hdr_pos[1:0] +: 8];
						pend_n = 1'b0;
					end
				end
				if (count_n != '0) begin
					b_valid = 1'b1;
					res_b = build(count_n, pfx_n, hdr_n, pend_n, 1'b1);
				end
				win_n = '0;
				fill_n = '0;
				skip_n = '0;
				count_n = '0;
				pfx_n = PFX_NONE;
				hdr_n = '0;
				pend_n = 1'b0;
			end
		end
	end

	assign push.first = a_valid || b_valid;
	assign push.second = a_valid && b_valid;
	assign res0 = a_valid ? res_a : res_b;
	assign res1 = res_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			fill_q <= '0;
			skip_q <= '0;
			count_q <= '0;
			pfx_q <= PFX_NONE;
			hdr_q <= '0;
			pend_q <= 1'b0;
		end else begin
			win_q <= win_n;
			fill_q <= fill_n;
			skip_q <= skip_n;
			count_q <= count_n;
			pfx_q <= pfx_n;
			hdr_q <= hdr_n;
			pend_q <= pend_n;
		end
	end

endmodule

FILE: rtl/anbs_outq.sv
// Result queue taking up to two results a cycle and giving one.
module anbs_outq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  anbs_pkg::push_t               push,
	input  anbs_pkg::result_t             wr0,
	input  anbs_pkg::result_t             wr1,
	input  logic                          pop,
	output anbs_pkg::result_t             head,
	output logic                          head_valid,
	output logic [anbs_pkg::OQ_CNT_W-1:0] level
);
	import anbs_pkg::*;

	result_t               entries_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [OQ_CNT_W-1:0]   count_q;
	logic [OQ_PTR_W-1:0]   wr_ptr_b;
	logic [OQ_CNT_W-1:0]   n_push;

	assign wr_ptr_b = wr_ptr_q + OQ_PTR_W'(1);
	assign n_push = OQ_CNT_W'(push.first) + OQ_CNT_W'(push.second);

	always_ff @(posedge clk) begin
		if (push.first) begin
			entries_q[wr_ptr_q] <= wr0;
		end
		if (push.second) begin
			entries_q[wr_ptr_b] <= wr1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			end
			count_q <= count_q + n_push - OQ_CNT_W'(pop);
		end
	end

	assign head = entries_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign level = count_q;

endmodule

FILE: rtl/annexb_nalu_splitter.sv
// Top level of the Annex B start code splitter: input register, scanner and result queue.
//
//   Channel    Dir  Transaction
//   stream_in  in   one stream byte with its end-of-stream flag
//   unit_out   out  one finished unit: length, start code length, header fields
//
// One byte is accepted per clock while stream_in.ready is high; a byte reaches the scanner from
// the input register in the cycle after acceptance, and its results are offered on unit_out from the result queue.
// A unit is reported only once the scanner sees the byte that ends it, which lies four
// bytes behind the stream; stream_end flushes the rest of the window.
// Results wait in an eight-entry queue; stream_in drops ready while more than four are held.
// arst_n clears the scanner state and empties the queue; no clearing pass is needed.
module annexb_nalu_splitter #(
	parameter int LENGTH_BITS = anbs_pkg::LENGTH_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	anbs_stream_if.sink  stream_in,
	anbs_unit_if.source  unit_out
);
	import anbs_pkg::*;

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                end_s1;
	logic                accept;
	push_t               push;
	result_t             res0, res1, head;
	logic                head_valid;
	logic                pop;
	logic [OQ_CNT_W-1:0] level;

	// Room is kept for two results from the byte in the input register and two from the next.
	assign stream_in.ready = (level <= OQ_CNT_W'(OQ_DEPTH - OQ_HEADROOM));
	assign accept = stream_in.valid && stream_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= stream_in.stream_byte;
			end_s1 <= stream_in.stream_end;
		end
	end

	anbs_scan #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(valid_s1),
		.item_byte (byte_s1),
		.item_end  (end_s1),
		.push      (push),
		.res0      (res0),
		.res1      (res1)
	);

	anbs_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr0       (res0),
		.wr1       (res1),
		.pop       (pop),
		.head      (head),
		.head_valid(head_valid),
		.level     (level)
	);

	assign pop = head_valid && unit_out.ready;

	assign unit_out.valid = head_valid;
	assign unit_out.unit_length = head.unit_length;
	assign unit_out.prefix_length = head.prefix_length;
	assign unit_out.forbidden_bit = head.forbidden_bit;
	assign unit_out.reference_level = head.reference_level;
	assign unit_out.unit_type = head.unit_type;
	assign unit_out.type_known = head.type_known;
	assign unit_out.final_unit = head.final_unit;

`ifndef SYNTH
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= OQ_CNT_W'(OQ_DEPTH))
		else $error("result queue holds more entries than it has");

	a_no_empty_unit: assert property (@(posedge clk) disable iff (!arst_n)
		unit_out.valid |-> unit_out.unit_length != '0)
		else $error("a unit of zero length was offered");

	a_known_needs_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		unit_out.valid && unit_out.type_known |->
			unit_out.prefix_length == PFX_SHORT || unit_out.prefix_length == PFX_LONG)
		else $error("a known type was reported for a unit without a start code");
`endif

endmodule
